/* src/mvtp_pkg.sv */
// ----------------------------------------------------------------------------
// mvtp_pkg
// Types and constants for the min-vruntime task picker files.
// ----------------------------------------------------------------------------
package mvtp_pkg;

	localparam int KIND_W    = 2;
	localparam int ID_W      = 8;
	localparam int SLOT_W    = 5;
	localparam int CHARGE_W  = 10;
	localparam int STATUS_W  = 2;
	localparam int STAMP_W   = 32;

	// Charges at or above this limit are clamped to one below it.
	localparam logic [CHARGE_W-1:0] CHARGE_LIMIT = 10'd1000;

	localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FINISH = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_STALLED = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [ID_W-1:0]     task_id;
		logic [SLOT_W-1:0]   slot;
		logic [CHARGE_W-1:0] charge;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ID_W-1:0]     charged_id;
		logic [ID_W-1:0]     next_id;
		logic [SLOT_W-1:0]   added_slot;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_DONE
	} state_t;

endpackage

/* src/mvtp_ram.sv */
// ----------------------------------------------------------------------------
// mvtp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mvtp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* src/min_vruntime_task_picker_core.sv */
// ----------------------------------------------------------------------------
// min_vruntime_task_picker_core
// Fair-share task picker: a table of tasks with virtual runtimes; a tick
// charges the least-vruntime task unless finished, and reports the minimum.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready   | in_data  (in_item_t)
//  out     | output    | out_valid / out_ready | out_data (out_item_t)
//
//  Add, finish and unknown items go from idle straight to done. A tick scans
//  the N stored tasks over the single read port of the task RAM, one read
//  per entry, writes back the charged minimum and scans again for the new
//  minimum. A tick that stops at a finished minimum skips the write-back.
//  Reset clears the task count, stamp counter, finished marks and control;
//  the RAM is not cleared, since entries at or above the count are never read.
//  A finished result waits in the output register while the next item is
//  accepted; the block stalls only when a new result finds that register full.
// ----------------------------------------------------------------------------
module min_vruntime_task_picker_core #(
	parameter int MAX_TASKS     = 32,
	parameter int RUNTIME_WIDTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  mvtp_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output mvtp_pkg::out_item_t  out_data
);

	import mvtp_pkg::*;

	localparam int IDX_W  = $clog2(MAX_TASKS);
	localparam int CNT_W  = $clog2(MAX_TASKS + 1);
	localparam int CMP_W  = CNT_W + SLOT_W;
	localparam int WORD_W = RUNTIME_WIDTH + STAMP_W + ID_W;
	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_TASKS);

	state_t state_q, state_d;

	in_item_t  item_q;
	out_item_t res_q;
	out_item_t res_d;
	out_item_t out_data_q;
	logic      out_valid_q;

	logic [CNT_W-1:0]   count_q;
	logic [STAMP_W-1:0] stamp_q;
	logic [MAX_TASKS-1:0] done_q;

	logic [CNT_W-1:0] iss_q;
	logic             pass_q;
	logic             rd_v_s1;
	logic [IDX_W-1:0] idx_s1;

	logic [RUNTIME_WIDTH-1:0] best_rt_q;
	logic [STAMP_W-1:0]       best_age_q;
	logic [IDX_W-1:0]         best_idx_q;
	logic [ID_W-1:0]          best_id_q;

	logic                 accept;
	logic                 issue_en;
	logic                 scan_end;
	logic                 out_load;
	logic                 we;
	logic [IDX_W-1:0]     waddr;
	logic [WORD_W-1:0]    wdata;
	logic [WORD_W-1:0]    rdata;
	logic [RUNTIME_WIDTH-1:0] rd_rt;
	logic [STAMP_W-1:0]   rd_stamp;
	logic [ID_W-1:0]      rd_id;
	logic [STAMP_W-1:0]   rd_age;
	logic                 rd_better;
	logic [CHARGE_W-1:0]  charge_c;
	logic [RUNTIME_WIDTH:0] sum;
	logic [RUNTIME_WIDTH-1:0] new_rt;
	logic [CMP_W-1:0]     slot_ext;
	logic [CMP_W-1:0]     count_ext;
	logic                 slot_live;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign slot_ext  = CMP_W'(in_data.slot);
	assign count_ext = CMP_W'(count_q);
	assign slot_live = slot_ext < count_ext;

	// Sequential scan: one read issued per cycle, compared in the cycle after.
	assign issue_en = (state_q == ST_SCAN) && (iss_q != count_q);
	assign scan_end = (state_q == ST_SCAN) && (iss_q == count_q) && !rd_v_s1;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	assign rd_rt    = rdata[WORD_W-1 -: RUNTIME_WIDTH];
	assign rd_stamp = rdata[ID_W +: STAMP_W];
	assign rd_id    = rdata[ID_W-1:0];
	assign rd_age   = stamp_q - rd_stamp;
	// An older stamp wins a tie; the first entry seeds the running minimum.
	assign rd_better = (idx_s1 == '0) || (rd_rt < best_rt_q) ||
		((rd_rt == best_rt_q) && (rd_age > best_age_q));

	assign charge_c = (item_q.charge >= CHARGE_LIMIT) ? (CHARGE_LIMIT - 10'd1)
		: item_q.charge;
	assign sum      = {1'b0, best_rt_q} + (RUNTIME_WIDTH + 1)'(charge_c);
	assign new_rt   = sum[RUNTIME_WIDTH] ? '1 : sum[RUNTIME_WIDTH-1:0];

	always_comb begin
		we    = 1'b0;
		waddr = best_idx_q;
		wdata = {new_rt, stamp_q, best_id_q};
		if (accept && (in_data.kind == KIND_ADD) && (count_q != FULL_COUNT)) begin
			we    = 1'b1;
			waddr = count_q[IDX_W-1:0];
			wdata = {{RUNTIME_WIDTH{1'b0}}, stamp_q, in_data.task_id};
		end else if (state_q == ST_WRITE) begin
			we = 1'b1;
		end
	end

	mvtp_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAX_TASKS)
	) u_task_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (issue_en),
		.raddr(iss_q[IDX_W-1:0]),
		.rdata(rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if ((in_data.kind == KIND_TICK) && (count_q != '0)) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					if (pass_q || done_q[best_idx_q]) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_WRITE;
					end
				end
			end
			ST_WRITE: state_d = ST_SCAN;
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// The result under construction; it moves to the output register when done.
	always_comb begin
		res_d = res_q;
		if (accept) begin
			res_d = '0;
			case (in_data.kind)
				KIND_ADD: begin
					if (count_q == FULL_COUNT) begin
						res_d.status = STATUS_FULL;
					end else begin
						res_d.added_slot = SLOT_W'(count_q);
					end
				end
				KIND_TICK: begin
					if (count_q == '0) begin
						res_d.status = STATUS_EMPTY;
					end
				end
				default: ;
			endcase
		end else if (scan_end) begin
			res_d.next_id = best_id_q;
			if (!pass_q && done_q[best_idx_q]) begin
				res_d.status = STATUS_STALLED;
			end
		end else if (state_q == ST_WRITE) begin
			res_d.charged_id = best_id_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			stamp_q     <= '0;
			done_q      <= '0;
			iss_q       <= '0;
			pass_q      <= 1'b0;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= issue_en;
			if (issue_en) begin
				iss_q <= iss_q + 1'b1;
			end
			if (accept) begin
				iss_q  <= '0;
				pass_q <= 1'b0;
				if ((in_data.kind == KIND_ADD) && (count_q != FULL_COUNT)) begin
					count_q <= count_q + 1'b1;
					stamp_q <= stamp_q + 1'b1;
					done_q[count_q[IDX_W-1:0]] <= 1'b0;
				end
				if ((in_data.kind == KIND_FINISH) && slot_live) begin
					done_q[slot_ext[IDX_W-1:0]] <= 1'b1;
				end
			end
			if (state_q == ST_WRITE) begin
				stamp_q <= stamp_q + 1'b1;
				iss_q   <= '0;
				pass_q  <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= iss_q[IDX_W-1:0];
		if (rd_v_s1 && rd_better) begin
			best_rt_q  <= rd_rt;
			best_age_q <= rd_age;
			best_idx_q <= idx_s1;
			best_id_q  <= rd_id;
		end
		if (accept) begin
			item_q <= in_data;
		end
		res_q <= res_d;
		if (out_load) begin
			out_data_q <= res_q;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("task count beyond table size");

	assert property (@(posedge clk) disable iff (!arst_n)
		issue_en |-> (iss_q < count_q))
		else $error("scan read beyond stored tasks");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |-> !done_q[best_idx_q])
		else $error("charge applied to a finished task");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |=> (stamp_q == $past(stamp_q) + 1'b1))
		else $error("stamp counter not advanced by a charge");

endmodule
